// ===== design/grid_simpson_integrator_2d_assert.svh =====
// Assertion macros used by the back part of the Simpson integrator.
`ifndef GRID_SIMPSON_INTEGRATOR_2D_ASSERT_SVH
`define GRID_SIMPSON_INTEGRATOR_2D_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GSI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gsi_pkg.sv =====
// Shared types and constants of the 2-D Simpson grid integrator.
package gsi_pkg;

    // Grid dimensions and field widths.
    localparam int MAX_DIM    = 4096;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int CNT_W      = 13;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 64;
    localparam int AREA_W     = 32;
    localparam int INTEGRAL_W = 64;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_COL_COUNT = 2'd1,
        CFG_TILE_AREA = 2'd2
    } t_cfg_reg;

    localparam logic [CNT_W-1:0]  ROW_COUNT_RST = CNT_W'(3);
    localparam logic [CNT_W-1:0]  COL_COUNT_RST = CNT_W'(3);
    localparam logic [AREA_W-1:0] TILE_AREA_RST = AREA_W'(65536);

    // Queue depths.
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 16;

    // Scaling: product shifted right by the Q16.16 fraction, then divided by nine.
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = SUM_W + AREA_W;
    localparam int SCALED_W   = PROD_W - FRAC_BITS;
    localparam int DIGIT_W    = 16;
    localparam int NUM_DIGITS = SCALED_W / DIGIT_W;
    localparam int DIVISOR    = 9;
    localparam int REM_W      = $clog2(DIVISOR);
    localparam int CUR_W      = REM_W + DIGIT_W;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W    = RECIP_SHIFT - $clog2(DIVISOR) + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);

    // One finished result as held in the output queue.
    typedef struct packed {
        logic [INTEGRAL_W-1:0] integral;
        logic                  saturated;
    } t_result;

endpackage

// ===== design/grid_simpson_integrator_2d.sv =====
// Top level of the 2-D composite Simpson grid integrator.
//
// Samples enter in row-major order through a queue-style port: a request is
// taken at a clock edge with push high and full low. Each sample is weighted
// by the product of its row and column Simpson factors and accumulated.
// After the last sample of a row_count x col_count grid one result request
// appears: integral = weighted sum * tile_area >> 16 / 9, rounded toward zero
// and clipped to 64 bits, with saturated set when clipped. A result is shown
// while empty is low and is taken at an edge with pop high.
// Throughput: one sample per cycle while full is low; the front adds one
// shifted sample per cycle and the back pipeline takes one grid sum per cycle
// while a result slot is free. A grid sum passes the sum queue, then the stages:
// magnitude, two half products, scaled sum, five divide-by-nine digit stages.
// When the receiver stalls, results collect in a 16-entry queue and finished
// grid sums in a 4-entry queue; full rises only once the latter fills.
// Configuration: i_cfg_we writes register i_cfg_index (0 row_count,
// 1 col_count, 2 tile_area); the user writes only while idle (not enforced).
// Reset (synchronous, active low) clears counters, sum and both queues and
// loads row_count 3, col_count 3 and tile_area 1.0.
module grid_simpson_integrator_2d
    import gsi_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [INTEGRAL_W-1:0] o_integral,
    output logic                         o_saturated,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    logic [CNT_W-1:0]  r_row_count;
    logic [CNT_W-1:0]  r_col_count;
    logic [AREA_W-1:0] r_tile_area;
    logic              accept;
    logic              sum_valid;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  q_sum;
    logic              q_empty;
    logic              q_pull;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
            r_tile_area <= TILE_AREA_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[CNT_W-1:0];
                CFG_COL_COUNT: r_col_count <= i_cfg_data[CNT_W-1:0];
                CFG_TILE_AREA: r_tile_area <= i_cfg_data[AREA_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = push && !full;

    gsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .i_row_count (r_row_count),
        .i_col_count (r_col_count),
        .o_sum_valid (sum_valid),
        .o_sum       (sum)
    );

    gsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (sum_valid),
        .i_wdata (sum),
        .i_rd    (q_pull),
        .o_rdata (q_sum),
        .o_full  (full),
        .o_empty (q_empty)
    );

    gsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sum_valid (!q_empty),
        .i_sum       (q_sum),
        .o_sum_pull  (q_pull),
        .i_tile_area (r_tile_area),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_integral  (o_integral),
        .o_saturated (o_saturated)
    );

endmodule

// ===== design/gsi_queue.sv =====
// Short queue of finished grid sums between the front and back parts.
module gsi_queue
    import gsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [SUM_W-1:0] i_wdata,
    input  logic             i_rd,
    output logic [SUM_W-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    logic [SUM_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              wr_ok, rd_ok;

    // Pointer and count update.
    always_comb begin
        wr_ok   = i_wr && !o_full;
        rd_ok   = i_rd && !o_empty;
        n_wptr  = wr_ok ? PTR_W'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = rd_ok ? PTR_W'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (wr_ok && !rd_ok) begin
            n_count = CNT_QW'(r_count + 1'b1);
        end else if (rd_ok && !wr_ok) begin
            n_count = CNT_QW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== design/gsi_front.sv =====
// Front part: grid position tracking, Simpson weighting and accumulation.
module gsi_front
    import gsi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [CNT_W-1:0]           i_row_count,
    input  logic [CNT_W-1:0]           i_col_count,
    output logic                       o_sum_valid,
    output logic [SUM_W-1:0]           o_sum
);

    localparam int SH_W = 3;

    // Last index of an axis after clamping the count into its legal range.
    function automatic logic [IDX_W-1:0] eff_last(input logic [CNT_W-1:0] n);
        int v;
        v = int'(n);
        if (v < 3) begin
            v = 3;
        end else if (v > MAX_DIM) begin
            v = MAX_DIM;
        end
        return IDX_W'(v - 1);
    endfunction

    // Weight as a shift: 1 at an edge, 4 at odd inner, 2 at even inner indices.
    function automatic logic [1:0] axis_shift(input logic [IDX_W-1:0] i,
                                              input logic [IDX_W-1:0] last);
        if (i == '0 || i >= last) begin
            return 2'd0;
        end
        return i[0] ? 2'd2 : 2'd1;
    endfunction

    logic [IDX_W-1:0] r_row_idx, n_row_idx;
    logic [IDX_W-1:0] r_col_idx, n_col_idx;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [IDX_W-1:0] row_last, col_last;
    logic             col_end, row_end;
    logic [SH_W-1:0]  shift;
    logic [SUM_W-1:0] sample_ext;
    logic [SUM_W-1:0] sum_next;

    // Weighted add and position advance.
    always_comb begin
        row_last   = eff_last(i_row_count);
        col_last   = eff_last(i_col_count);
        col_end    = (r_col_idx >= col_last);
        row_end    = (r_row_idx >= row_last);
        shift      = SH_W'(axis_shift(r_row_idx, row_last))
                   + SH_W'(axis_shift(r_col_idx, col_last));
        sample_ext = {{(SUM_W - SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
        sum_next   = r_sum + (sample_ext << shift);

        n_row_idx = r_row_idx;
        n_col_idx = r_col_idx;
        n_sum     = r_sum;
        if (i_accept) begin
            n_sum = sum_next;
            if (!col_end) begin
                n_col_idx = IDX_W'(r_col_idx + 1'b1);
            end else begin
                n_col_idx = '0;
                if (!row_end) begin
                    n_row_idx = IDX_W'(r_row_idx + 1'b1);
                end else begin
                    n_row_idx = '0;
                    n_sum     = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_idx <= '0;
            r_col_idx <= '0;
            r_sum     <= '0;
        end else begin
            r_row_idx <= n_row_idx;
            r_col_idx <= n_col_idx;
            r_sum     <= n_sum;
        end
    end

    // The grid's final sum goes to the queue in the cycle of its last sample.
    assign o_sum_valid = i_accept && col_end && row_end;
    assign o_sum       = sum_next;

endmodule

// ===== design/gsi_back.sv =====
// Back part: scaling pipeline, divide by nine, saturation and result queue.
`include "grid_simpson_integrator_2d_assert.svh"

module gsi_back
    import gsi_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_sum_valid,
    input  logic [SUM_W-1:0]             i_sum,
    output logic                         o_sum_pull,
    input  logic [AREA_W-1:0]            i_tile_area,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic signed [INTEGRAL_W-1:0] o_integral,
    output logic                         o_saturated
);

    // Magnitude, products, scaled word, then one stage per quotient digit.
    localparam int STAGES = 3 + NUM_DIGITS;
    localparam int HALF_W = SUM_W / 2;
    localparam int OPTR_W = $clog2(OUT_DEPTH);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam int QHI_W  = SCALED_W - INTEGRAL_W;
    localparam logic [INTEGRAL_W-1:0] POS_LIMIT = {1'b0, {(INTEGRAL_W - 1){1'b1}}};
    localparam logic [INTEGRAL_W-1:0] NEG_LIMIT = {1'b1, {(INTEGRAL_W - 1){1'b0}}};

    logic                  r_vld [STAGES];
    logic                  r_neg [STAGES];
    logic [SUM_W-1:0]      r_mag;
    logic [SUM_W-1:0]      r_lo, r_hi;
    logic [SCALED_W-1:0]   r_word [NUM_DIGITS+1];
    logic [REM_W-1:0]      r_rem  [NUM_DIGITS+1];
    t_result               r_omem [OUT_DEPTH];
    logic [OPTR_W-1:0]     r_owr, r_ord;
    logic [OCNT_W-1:0]     r_ocnt, n_ocnt;
    logic [OCNT_W-1:0]     r_occ, n_occ;

    logic                  in_neg;
    logic [SUM_W-1:0]      in_mag;
    logic [SUM_W-1:0]      lo_prod, hi_prod;
    logic [PROD_W-1:0]     full_prod;
    logic [CUR_W-1:0]      cur    [NUM_DIGITS];
    logic [CUR_W+RECIP_W-1:0] qprod [NUM_DIGITS];
    logic [DIGIT_W-1:0]    qdig   [NUM_DIGITS];
    logic [CUR_W-1:0]      qnine  [NUM_DIGITS];
    logic [REM_W-1:0]      nrem   [NUM_DIGITS];
    logic [SCALED_W-1:0]   nword  [NUM_DIGITS];
    logic [SCALED_W-1:0]   quo;
    logic                  fin_neg;
    logic [INTEGRAL_W-1:0] limit;
    logic                  over;
    logic [INTEGRAL_W-1:0] clipped;
    t_result               fin;
    logic                  fin_wr;
    logic                  pop_ok;
    t_result               head;

    // Request pull from the queue only while the result queue has a slot to reserve.
    assign o_sum_pull = i_sum_valid && (r_occ < OCNT_W'(OUT_DEPTH));
    assign pop_ok     = i_pop && !o_empty;
    assign fin_wr     = r_vld[STAGES-1];

    // Sign and magnitude of the grid sum.
    always_comb begin
        in_neg = i_sum[SUM_W-1];
        in_mag = in_neg ? (~i_sum + 1'b1) : i_sum;
    end

    // Two half products, then their sum with the fraction dropped.
    always_comb begin
        lo_prod   = r_mag[HALF_W-1:0] * i_tile_area;
        hi_prod   = r_mag[SUM_W-1:HALF_W] * i_tile_area;
        full_prod = {{(PROD_W - SUM_W){1'b0}}, r_lo} + {r_hi, {HALF_W{1'b0}}};
    end

    // Divide by nine one digit per stage, using a reciprocal multiply.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            cur[d]   = {r_rem[d], r_word[d][SCALED_W-1 -: DIGIT_W]};
            qprod[d] = cur[d] * RECIP;
            qdig[d]  = qprod[d][RECIP_SHIFT +: DIGIT_W];
            qnine[d] = (CUR_W'(qdig[d]) << 3) + CUR_W'(qdig[d]);
            nrem[d]  = REM_W'(cur[d] - qnine[d]);
            nword[d] = {r_word[d][SCALED_W-DIGIT_W-1:0], qdig[d]};
        end
    end

    // Clip to the signed range and restore the sign.
    always_comb begin
        quo     = r_word[NUM_DIGITS];
        fin_neg = r_neg[STAGES-1];
        limit   = fin_neg ? NEG_LIMIT : POS_LIMIT;
        over    = (quo[SCALED_W-1 -: QHI_W] != '0) || (quo[INTEGRAL_W-1:0] > limit);
        clipped = over ? limit : quo[INTEGRAL_W-1:0];
        fin.integral  = fin_neg ? (~clipped + 1'b1) : clipped;
        fin.saturated = over;
    end

    // Occupancy and result queue count.
    always_comb begin
        n_occ  = r_occ;
        n_ocnt = r_ocnt;
        if (o_sum_pull && !pop_ok) begin
            n_occ = OCNT_W'(r_occ + 1'b1);
        end else if (pop_ok && !o_sum_pull) begin
            n_occ = OCNT_W'(r_occ - 1'b1);
        end
        if (fin_wr && !pop_ok) begin
            n_ocnt = OCNT_W'(r_ocnt + 1'b1);
        end else if (pop_ok && !fin_wr) begin
            n_ocnt = OCNT_W'(r_ocnt - 1'b1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
            r_occ  <= '0;
        end else begin
            r_vld[0] <= o_sum_pull;
            for (int k = 1; k < STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (fin_wr) begin
                r_owr <= OPTR_W'(r_owr + 1'b1);
            end
            if (pop_ok) begin
                r_ord <= OPTR_W'(r_ord + 1'b1);
            end
            r_ocnt <= n_ocnt;
            r_occ  <= n_occ;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_neg[0] <= in_neg;
        for (int k = 1; k < STAGES; k++) begin
            r_neg[k] <= r_neg[k-1];
        end
        r_mag     <= in_mag;
        r_lo      <= lo_prod;
        r_hi      <= hi_prod;
        r_word[0] <= full_prod[PROD_W-1:FRAC_BITS];
        r_rem[0]  <= '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            r_word[d+1] <= nword[d];
            r_rem[d+1]  <= nrem[d];
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (fin_wr) begin
            r_omem[r_owr] <= fin;
        end
    end

    assign head        = r_omem[r_ord];
    assign o_empty     = (r_ocnt == '0);
    assign o_integral  = signed'(head.integral);
    assign o_saturated = head.saturated;

    `GSI_ASSERT_SAME(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCNT_W'(OUT_DEPTH), "occupancy above result queue depth")
    `GSI_ASSERT_SAME(a_queue_within_occ, i_clk, i_rst_n, 1'b1, r_ocnt <= r_occ, "result queue holds more than was pulled")
    `GSI_ASSERT_SAME(a_room_at_finish, i_clk, i_rst_n, fin_wr, r_ocnt < OCNT_W'(OUT_DEPTH), "finished result with no queue slot")
    `GSI_ASSERT_NEXT(a_pull_enters, i_clk, i_rst_n, o_sum_pull, r_vld[0], "pulled sum did not enter the pipeline")
    `GSI_ASSERT_SAME(a_sat_value, i_clk, i_rst_n, !o_empty && o_saturated, $unsigned(o_integral) == POS_LIMIT || $unsigned(o_integral) == NEG_LIMIT, "saturated result is not a range limit")

endmodule
